// ===== sv/spow_pkg.sv =====
// ----------------------------------------------------------------------------
// spow_pkg
// Shared types, constants and helpers of the spiral order address walker.
// ----------------------------------------------------------------------------
package spow_pkg;

  // Grid limits and field widths
  localparam int unsigned MaxSide    = 1024;
  localparam int unsigned MaxWidth   = 16;
  localparam int unsigned SideW      = 11;
  localparam int unsigned FieldWW    = 5;
  localparam int unsigned ValueW     = 21;
  localparam int unsigned CoordW     = 10;
  localparam int unsigned RingW      = 9;
  localparam int unsigned ProdW      = 20;
  localparam int unsigned OffsetW    = 25;
  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;
  localparam int unsigned OutTdataW  = 72;
  localparam int unsigned InTdataW   = 8;

  // Reset values of the configuration registers
  localparam logic [SideW-1:0]   SideReset  = SideW'(4);
  localparam logic [FieldWW-1:0] WidthReset = FieldWW'(4);

  // Register indexes
  localparam logic RegSide       = 1'b0;
  localparam logic RegFieldWidth = 1'b1;

  // Configuration write from the bus side
  typedef struct packed {
    logic             wr;
    logic             idx;
    logic [DataW-1:0] data;
  } cfg_wr_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // latch restart flag of the accepted transaction
    logic calc_total;  // register n*n
    logic walk;        // move to the next cell or restart
    logic calc_prod;   // register n*row
    logic calc_lin;    // register n*row+col
    logic load_out;    // register the result
  } cmd_t;

  // Effective side length, clamped to 1..MaxSide
  function automatic logic [SideW-1:0] eff_side(input logic [SideW-1:0] s);
    logic [SideW-1:0] r;
    if (s == '0) begin
      r = SideW'(1);
    end else if (s > SideW'(MaxSide)) begin
      r = SideW'(MaxSide);
    end else begin
      r = s;
    end
    return r;
  endfunction

  // Effective field width, clamped to 1..MaxWidth
  function automatic logic [FieldWW-1:0] eff_width(input logic [FieldWW-1:0] w);
    logic [FieldWW-1:0] r;
    if (w == '0) begin
      r = FieldWW'(1);
    end else if (w > FieldWW'(MaxWidth)) begin
      r = FieldWW'(MaxWidth);
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

// ===== sv/spiral_order_address_walker_unit.sv =====
// ----------------------------------------------------------------------------
// spiral_order_address_walker_unit
// Steps through an N by N grid in clockwise spiral order and reports the
// number, row, column and text image byte offset of each cell.
// ----------------------------------------------------------------------------
// Each input transaction (restart flag) produces one output transaction. The
// result of a step is registered after these phases in order: the n*n
// product, the spiral move, the n*row product, the column add and the final
// field_width multiply-add, all sequenced by one controller over a single
// shared datapath, so one step is in flight at a time and a new step is
// accepted only after the last one has left its final phase. The next
// step is accepted while a finished result still waits on the output; that
// step then holds in its last phase until the output is taken. A write to
// either register restarts the walk at the top-left cell.
module spiral_order_address_walker_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // restart [0]
  input  logic [spow_pkg::InTdataW-1:0]    s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // value [20:0], row [30:21], col [40:31], byte_offset [65:41]
  output logic [spow_pkg::OutTdataW-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [spow_pkg::AddrW-1:0]       paddr,
  input  logic [spow_pkg::DataW-1:0]       pwdata,
  output logic [spow_pkg::DataW-1:0]       prdata,
  output logic                             pready
);

  spow_pkg::cmd_t                   cmd;
  spow_pkg::cfg_wr_t                cfg;
  logic [spow_pkg::ValueW-1:0]      value;
  logic [spow_pkg::CoordW-1:0]      row;
  logic [spow_pkg::CoordW-1:0]      col;
  logic [spow_pkg::OffsetW-1:0]     byte_offset;

  // Decode the register write
  assign pready   = 1'b1;
  assign cfg.wr   = psel && penable && pwrite;
  assign cfg.idx  = paddr[2];
  assign cfg.data = pwdata;

  spow_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  spow_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg),
    .restart_i     (s_axis_tdata[0]),
    .rd_idx_i      (paddr[2]),
    .rd_data_o     (prdata),
    .value_o       (value),
    .row_o         (row),
    .col_o         (col),
    .byte_offset_o (byte_offset),
    .last_o        (m_axis_tlast)
  );

  // Pack the result fields
  assign m_axis_tdata = {6'b0, byte_offset, col, row, value};

endmodule

// ===== sv/spow_ctrl.sv =====
// ----------------------------------------------------------------------------
// spow_ctrl
// Sequencer of the walker: accepts one step, runs the datapath through its
// phases and holds the result until the output side takes it.
// ----------------------------------------------------------------------------
module spow_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spow_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StTotal,
    StWalk,
    StProd,
    StLin,
    StOff
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Decode commands and next state
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StTotal;
        end
      end
      StTotal: begin
        cmd_o.calc_total = 1'b1;
        state_d          = StWalk;
      end
      StWalk: begin
        cmd_o.walk = 1'b1;
        state_d    = StProd;
      end
      StProd: begin
        cmd_o.calc_prod = 1'b1;
        state_d         = StLin;
      end
      StLin: begin
        cmd_o.calc_lin = 1'b1;
        state_d        = StOff;
      end
      StOff: begin
        // Hold until the output register is free
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/spow_dp.sv =====
// ----------------------------------------------------------------------------
// spow_dp
// Datapath of the walker: configuration registers, spiral position state,
// cell count, offset arithmetic and result registers.
// ----------------------------------------------------------------------------
module spow_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  spow_pkg::cmd_t                      cmd_i,
  input  spow_pkg::cfg_wr_t                   cfg_i,
  input  logic                                restart_i,
  input  logic                                rd_idx_i,
  output logic [spow_pkg::DataW-1:0]          rd_data_o,
  output logic [spow_pkg::ValueW-1:0]         value_o,
  output logic [spow_pkg::CoordW-1:0]         row_o,
  output logic [spow_pkg::CoordW-1:0]         col_o,
  output logic [spow_pkg::OffsetW-1:0]        byte_offset_o,
  output logic                                last_o
);

  typedef enum logic [1:0] {
    DirRight,
    DirDown,
    DirLeft,
    DirUp
  } dir_e;

  localparam int unsigned CW = spow_pkg::CoordW;

  logic [spow_pkg::SideW-1:0]   side_q;
  logic [spow_pkg::FieldWW-1:0] width_q;
  logic [spow_pkg::SideW-1:0]   n_eff;
  logic [spow_pkg::FieldWW-1:0] w_eff;
  logic                         restart_q;
  logic [spow_pkg::ValueW-1:0]  total_q;
  logic [spow_pkg::ValueW-1:0]  counter_q, counter_d;
  logic [CW-1:0]                row_q, row_d, col_q, col_d;
  dir_e                         dir_q, dir_d;
  logic [spow_pkg::RingW-1:0]   ring_q, ring_d;
  logic [CW-1:0]                edge_q, edge_d;
  logic [spow_pkg::ProdW-1:0]   prod_q;
  logic [spow_pkg::ProdW-1:0]   lin_q;
  logic [spow_pkg::OffsetW-1:0] off_full;
  logic [CW-1:0]                lo_ext;
  logic                         start_walk;

  assign n_eff  = spow_pkg::eff_side(side_q);
  assign w_eff  = spow_pkg::eff_width(width_q);
  assign lo_ext = CW'(ring_q);

  // Read back the configuration registers
  always_comb begin
    unique case (rd_idx_i)
      spow_pkg::RegSide:       rd_data_o = spow_pkg::DataW'(side_q);
      spow_pkg::RegFieldWidth: rd_data_o = spow_pkg::DataW'(width_q);
      default:                 rd_data_o = '0;
    endcase
  end

  // Restart on request, before the first cell or after the last one
  assign start_walk = restart_q || (counter_q == '0) || (counter_q >= total_q);

  // Advance the spiral position one cell, or restart at the top-left cell
  always_comb begin
    row_d     = row_q;
    col_d     = col_q;
    dir_d     = dir_q;
    ring_d    = ring_q;
    edge_d    = edge_q;
    counter_d = counter_q + spow_pkg::ValueW'(1);
    if (start_walk) begin
      row_d     = '0;
      col_d     = '0;
      dir_d     = DirRight;
      ring_d    = '0;
      edge_d    = CW'(n_eff - spow_pkg::SideW'(1));
      counter_d = spow_pkg::ValueW'(1);
    end else begin
      unique case (dir_q)
        DirRight: begin
          if (col_q < edge_q) begin
            col_d = col_q + CW'(1);
          end else begin
            dir_d = DirDown;
            row_d = row_q + CW'(1);
          end
        end
        DirDown: begin
          if (row_q < edge_q) begin
            row_d = row_q + CW'(1);
          end else begin
            dir_d = DirLeft;
            if (col_q != '0) col_d = col_q - CW'(1);
          end
        end
        DirLeft: begin
          if (col_q > lo_ext) begin
            col_d = col_q - CW'(1);
          end else begin
            dir_d = DirUp;
            if (row_q != '0) row_d = row_q - CW'(1);
          end
        end
        DirUp: begin
          if (row_q > lo_ext + CW'(1)) begin
            row_d = row_q - CW'(1);
          end else begin
            ring_d = ring_q + spow_pkg::RingW'(1);
            if (edge_q != '0) edge_d = edge_q - CW'(1);
            dir_d = DirRight;
            col_d = col_q + CW'(1);
          end
        end
        default: dir_d = DirRight;
      endcase
    end
  end

  assign off_full = spow_pkg::OffsetW'(w_eff) * spow_pkg::OffsetW'(lin_q)
                  + spow_pkg::OffsetW'(row_q);

  // Hold configuration and walk control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q    <= spow_pkg::SideReset;
      width_q   <= spow_pkg::WidthReset;
      counter_q <= '0;
      row_q     <= '0;
      col_q     <= '0;
      dir_q     <= DirRight;
      ring_q    <= '0;
      edge_q    <= CW'(spow_pkg::SideReset - spow_pkg::SideW'(1));
    end else begin
      if (cfg_i.wr) begin
        // Any register write starts the walk over
        counter_q <= '0;
        if (cfg_i.idx == spow_pkg::RegSide) begin
          side_q <= cfg_i.data[spow_pkg::SideW-1:0];
        end else begin
          width_q <= cfg_i.data[spow_pkg::FieldWW-1:0];
        end
      end else if (cmd_i.walk) begin
        counter_q <= counter_d;
        row_q     <= row_d;
        col_q     <= col_d;
        dir_q     <= dir_d;
        ring_q    <= ring_d;
        edge_q    <= edge_d;
      end
    end
  end

  // Payload registers of the arithmetic phases and the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) restart_q <= restart_i;
    if (cmd_i.calc_total) begin
      total_q <= spow_pkg::ValueW'(n_eff) * spow_pkg::ValueW'(n_eff);
    end
    if (cmd_i.calc_prod) prod_q <= spow_pkg::ProdW'(n_eff) * spow_pkg::ProdW'(row_q);
    if (cmd_i.calc_lin) lin_q <= prod_q + spow_pkg::ProdW'(col_q);
    if (cmd_i.load_out) begin
      value_o       <= counter_q;
      row_o         <= row_q;
      col_o         <= col_q;
      byte_offset_o <= off_full;
      last_o        <= (counter_q == total_q);
    end
  end

endmodule

// ===== sv/spow_checker.sv =====
// ----------------------------------------------------------------------------
// spow_checker
// Port-level checks of the spiral walker, bound to the top level.
// ----------------------------------------------------------------------------
module spow_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [spow_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready
);

  // One step in flight: no new transaction right after an accepted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // Cell numbers start at one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[20:0] != '0))
    else $error("cell number zero");

  // The first cell is the top-left one at offset zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[20:0] == 21'd1)) |->
      (m_axis_tdata[65:21] == '0))
    else $error("first cell not at top-left");

  // A waiting result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped or changed while stalled");

endmodule

bind spiral_order_address_walker_unit spow_checker u_spow_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
